// File: rtl/core/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared types and constants for the bucketed hash set: operation and status
// codes, controller states, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bhs_pkg;

  // Fixed port widths.
  localparam int unsigned KEY_PORT_W   = 32;
  localparam int unsigned BCOUNT_W     = 8;
  localparam int unsigned COUNT_PORT_W = 10;

  // Parameter defaults.
  localparam int unsigned MAX_BUCKETS_DEF = 128;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned KEY_WIDTH_DEF   = 32;

  // Bucket count after reset.
  localparam logic [BCOUNT_W-1:0] RESET_BUCKETS = 8'd100;

  // Operation codes. The unused code behaves as a lookup.
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_NOCHANGE = 2'd1,
    STS_FULL     = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EVAL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic div;
    logic read;
    logic eval;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic div_last;
  } stat_t;

endpackage

// File: rtl/core/bhs_ram.sv
// ----------------------------------------------------------------------------
// bhs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bhs_ctrl.sv
// ----------------------------------------------------------------------------
// bhs_ctrl
// Controller for the bucketed hash set. Sequences the clearing sweep after
// reset, the bit-serial bucket selection, the bucket read and the
// compare/write-back step.
// ----------------------------------------------------------------------------
module bhs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bhs_pkg::stat_t stat_i,
  output bhs_pkg::cmd_t  cmd_o
);

  import bhs_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/core/bhs_dp.sv
// ----------------------------------------------------------------------------
// bhs_dp
// Datapath for the bucketed hash set: bucket count register, bit-serial
// remainder unit, bucket row RAM, way compare and write-back, element count
// and the result registers.
// ----------------------------------------------------------------------------
module bhs_dp #(
  parameter int unsigned MAX_BUCKETS = bhs_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned WAYS        = bhs_pkg::WAYS_DEF,
  parameter int unsigned KEY_WIDTH   = bhs_pkg::KEY_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bhs_pkg::cmd_t                      cmd_i,
  output bhs_pkg::stat_t                     stat_o,
  input  logic                               bucket_count_we_i,
  input  logic [bhs_pkg::BCOUNT_W-1:0]       bucket_count_i,
  input  logic [1:0]                         opcode_i,
  input  logic [bhs_pkg::KEY_PORT_W-1:0]     key_i,
  output logic                               result_valid_o,
  output logic                               was_present_o,
  output logic [1:0]                         status_o,
  output logic [bhs_pkg::COUNT_PORT_W-1:0]   element_count_o,
  output logic                               is_empty_o
);

  import bhs_pkg::*;

  localparam int unsigned KW    = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int unsigned AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned BW    = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned SW    = $clog2(KW);
  localparam int unsigned ENT_W = KW + 1;
  localparam int unsigned ROW_W = WAYS * ENT_W;
  localparam int unsigned SLOTS = MAX_BUCKETS * WAYS;
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [SW-1:0] STEP_TOP   = SW'(KW - 1);
  localparam logic [AW-1:0] CLEAR_TOP  = AW'(MAX_BUCKETS - 1);
  localparam logic [15:0]   MAX_B_WIDE = 16'(MAX_BUCKETS);

  // Configuration and operand registers.
  logic [BCOUNT_W-1:0] bcount_q;
  logic [1:0]          op_q;
  logic [KW-1:0]       key_q;
  logic [BW-1:0]       div_q, div_d;
  logic [BW-1:0]       rem_q, rem_d;
  logic [SW-1:0]       step_q;
  logic [AW-1:0]       clr_addr_q;
  logic [CW-1:0]       count_q, count_d;
  logic                valid_q;
  logic                was_q, was_d;
  logic [1:0]          status_q, status_d;

  // RAM signals.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [AW-1:0]    bucket;

  // Compare results.
  logic             hit;
  logic             has_free;
  logic [WW-1:0]    hit_way;
  logic [WW-1:0]    free_way;
  logic             do_insert;
  logic             do_remove;
  logic [ROW_W-1:0] new_row;

  // Bucket count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcount_q <= RESET_BUCKETS;
    end else if (bucket_count_we_i) begin
      bcount_q <= bucket_count_i;
    end
  end

  // Effective divisor: zero counts as one, large counts saturate.
  always_comb begin
    if (bcount_q == '0) begin
      div_d = BW'(1);
    end else if ({8'd0, bcount_q} > MAX_B_WIDE) begin
      div_d = BW'(MAX_BUCKETS);
    end else begin
      div_d = BW'(bcount_q);
    end
  end

  // Restoring remainder step: one key bit per cycle, most significant first.
  always_comb begin
    logic [BW:0]     trial;
    logic [SW-1:0]   bit_idx;
    bit_idx = STEP_TOP - step_q;
    trial   = {rem_q, key_q[bit_idx]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = BW'(trial - {1'b0, div_q});
    end else begin
      rem_d = BW'(trial);
    end
  end

  // Operand capture and the remainder iteration.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_i[KW-1:0];
      div_q <= div_d;
      rem_q <= '0;
    end else if (cmd_i.div) begin
      rem_q <= rem_d;
    end
  end

  // Step counter for the remainder unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.div) begin
      step_q <= step_q + SW'(1);
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign stat_o.clear_last = (clr_addr_q == CLEAR_TOP);
  assign stat_o.div_last   = (step_q == STEP_TOP);

  // The remainder is below the divisor, so its low bits address the bucket.
  assign bucket = rem_q[AW-1:0];

  // Way compare: first matching valid way and lowest free way.
  always_comb begin
    logic            v;
    logic [KW-1:0]   k;
    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int unsigned w = 0; w < WAYS; w++) begin
      v = ram_rdata[w*ENT_W + KW];
      k = ram_rdata[w*ENT_W +: KW];
      if (v) begin
        if (!hit && (k == key_q)) begin
          hit     = 1'b1;
          hit_way = WW'(w);
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  // Operation decode, status and count update.
  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    count_d   = count_q;
    was_d     = hit;
    case (op_q)
      OP_ADD: begin
        if (hit) begin
          status_d = STS_NOCHANGE;
        end else if (has_free) begin
          do_insert = 1'b1;
          count_d   = count_q + CW'(1);
          status_d  = STS_DONE;
        end else begin
          status_d = STS_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          do_remove = 1'b1;
          if (count_q != '0) begin
            count_d = count_q - CW'(1);
          end
          status_d = STS_DONE;
        end else begin
          status_d = STS_NOCHANGE;
        end
      end
      default: begin
        status_d = hit ? STS_DONE : STS_NOCHANGE;
      end
    endcase
  end

  // Modified bucket row for write-back.
  always_comb begin
    new_row = ram_rdata;
    for (int unsigned w = 0; w < WAYS; w++) begin
      if (do_insert && (free_way == WW'(w))) begin
        new_row[w*ENT_W +: ENT_W] = {1'b1, key_q};
      end
      if (do_remove && (hit_way == WW'(w))) begin
        new_row[w*ENT_W + KW] = 1'b0;
      end
    end
  end

  // RAM port muxing: the clearing sweep writes empty rows.
  assign ram_we    = cmd_i.clear || (cmd_i.eval && (do_insert || do_remove));
  assign ram_waddr = cmd_i.clear ? clr_addr_q : bucket;
  assign ram_wdata = cmd_i.clear ? '0 : new_row;

  bhs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (bucket),
    .rdata_o (ram_rdata)
  );

  // Element count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.eval;
      if (cmd_i.eval) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      was_q    <= was_d;
      status_q <= status_d;
    end
  end

  assign result_valid_o  = valid_q;
  assign was_present_o   = was_q;
  assign status_o        = status_q;
  assign element_count_o = COUNT_PORT_W'(count_q);
  assign is_empty_o      = (count_q == '0);

endmodule

// File: rtl/core/bucketed_hash_set.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set
// Set of keys stored in a table of buckets with a fixed number of ways; the
// bucket is the key modulo a configurable bucket count.
// ----------------------------------------------------------------------------
// Each operation (add, remove, contains) is accepted when start is high and
// busy is low. Its result appears on the result ports for exactly one cycle,
// marked by result_valid_o; only KEY_WIDTH key bits are used, at most the
// 32 bits of the port. The receiver cannot stall it. The result comes from
// the bit-serial remainder unit, which takes one key bit per cycle to pick
// the bucket, followed by a bucket row read from the RAM and a
// compare/write-back step. busy stays high for the whole operation and drops
// in the result cycle, so operations are taken one at a time. After reset the
// block clears its bucket RAM, one row per cycle, and holds busy high
// throughout. The bucket count may be written at any time the block is idle,
// including during that sweep.
module bucketed_hash_set #(
  parameter int unsigned MAX_BUCKETS = bhs_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned WAYS        = bhs_pkg::WAYS_DEF,
  parameter int unsigned KEY_WIDTH   = bhs_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             bucket_count_we_i,
  input  logic [bhs_pkg::BCOUNT_W-1:0]     bucket_count_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode_i,
  input  logic [bhs_pkg::KEY_PORT_W-1:0]   key_i,
  output logic                             result_valid_o,
  output logic                             was_present_o,
  output logic [1:0]                       status_o,
  output logic [bhs_pkg::COUNT_PORT_W-1:0] element_count_o,
  output logic                             is_empty_o
);

  import bhs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  bhs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Storage, remainder unit and result logic.
  bhs_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .WAYS        (WAYS),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .bucket_count_we_i (bucket_count_we_i),
    .bucket_count_i    (bucket_count_i),
    .opcode_i          (opcode_i),
    .key_i             (key_i),
    .result_valid_o    (result_valid_o),
    .was_present_o     (was_present_o),
    .status_o          (status_o),
    .element_count_o   (element_count_o),
    .is_empty_o        (is_empty_o)
  );

endmodule

// File: rtl/core/bhs_checker.sv
// ----------------------------------------------------------------------------
// bhs_checker
// Port-level checks for the bucketed hash set, bound to the top level.
// ----------------------------------------------------------------------------
module bhs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       was_present_o,
  input logic [1:0] status_o
);

  import bhs_pkg::*;

  // An accepted beat makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A result beat lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // A result is delivered only once the operation has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // A rejected add never reports the key as present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STS_FULL)) |-> !was_present_o)
    else $error("bucket full reported for a present key");

  // Status code is always one of the defined codes on a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == STS_DONE || status_o == STS_NOCHANGE ||
                        status_o == STS_FULL))
    else $error("undefined status code");

endmodule

bind bucketed_hash_set bhs_checker u_bhs_checker (.*);

// File: tb/sv/bucketed_hash_set_test.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set_test
// Self-checking bench for the bucketed hash set. A short table of directed
// operations covers the reset state, key extremes, a full bucket and the
// unused opcode. Random phases follow, each under its own bucket count, with
// the extremes among them. Every result beat is checked against the answer of a
// typed row or else against an in-bench model of the bucket table.
// ----------------------------------------------------------------------------
module bucketed_hash_set_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhs_pkg::*;

  localparam int unsigned SLOTS            = MAX_BUCKETS_DEF * WAYS_DEF;
  localparam logic [1:0]  OP_UNUSED        = 2'd3;
  localparam int unsigned DIR_ROWS         = 23;
  localparam int unsigned PHASES           = 11;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned MAX_GAP          = 11;

  // One result beat, split into its fields.
  typedef struct packed {
    logic                    was_present;
    status_e                 status;
    logic [COUNT_PORT_W-1:0] count;
    logic                    empty;
  } outcome_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct packed {
    logic [1:0]            op;
    logic [KEY_PORT_W-1:0] key;
    logic                  typed;
    outcome_t              want;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    bucket_count_we_i;
  logic [BCOUNT_W-1:0]     bucket_count_i;
  logic                    start;
  logic                    busy;
  logic [1:0]              opcode_i;
  logic [KEY_PORT_W-1:0]   key_i;
  logic                    result_valid_o;
  logic                    was_present_o;
  logic [1:0]              status_o;
  logic [COUNT_PORT_W-1:0] element_count_o;
  logic                    is_empty_o;

  // Shadow copy of the bucket table and the bucket-count register.
  logic [KEY_PORT_W-1:0] shadow_key [SLOTS];
  bit                    shadow_used [SLOTS];
  int unsigned           shadow_count;
  logic [BCOUNT_W-1:0]   cfg_buckets;

  outcome_t    pending_q [$];
  dir_row_t    dir_rows [DIR_ROWS];
  int unsigned mismatches;
  int unsigned ops_sent;
  int unsigned results_seen;
  int unsigned full_rejects;
  int unsigned peak_count;
  int unsigned settings_used;
  bit          idle_off;

  bucketed_hash_set u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bucket_count_we_i(bucket_count_we_i),
    .bucket_count_i   (bucket_count_i),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .key_i            (key_i),
    .result_valid_o   (result_valid_o),
    .was_present_o    (was_present_o),
    .status_o         (status_o),
    .element_count_o  (element_count_o),
    .is_empty_o       (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Applies one operation to the shadow table and returns its result beat.
  function automatic outcome_t apply_set_op(logic [1:0] op, logic [KEY_PORT_W-1:0] key);
    longint unsigned divisor;
    int unsigned     base;
    int              hit;
    int              free_way;
    outcome_t        res;
    divisor = cfg_buckets;
    if (divisor == 0) divisor = 1;
    if (divisor > MAX_BUCKETS_DEF) divisor = MAX_BUCKETS_DEF;
    base = int'((longint'(key) % divisor) * WAYS_DEF);
    hit = -1;
    free_way = -1;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (shadow_used[base + w]) begin
        if (hit < 0 && shadow_key[base + w] == key) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (op == OP_ADD) begin
      if (hit >= 0) begin
        res.status = STS_NOCHANGE;
      end else if (free_way >= 0) begin
        shadow_key[base + free_way]  = key;
        shadow_used[base + free_way] = 1'b1;
        shadow_count++;
        res.status = STS_DONE;
      end else begin
        res.status = STS_FULL;
      end
    end else if (op == OP_REMOVE) begin
      if (hit >= 0) begin
        shadow_used[base + hit] = 1'b0;
        shadow_count--;
        res.status = STS_DONE;
      end else begin
        res.status = STS_NOCHANGE;
      end
    end else begin
      // Contains, and the unused code, only look.
      res.status = (hit >= 0) ? STS_DONE : STS_NOCHANGE;
    end
    res.was_present = (hit >= 0);
    res.count       = shadow_count[COUNT_PORT_W-1:0];
    res.empty       = (shadow_count == 0);
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned want_v,
                                      longint unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want_v, got_v);
    end
  endfunction

  // Presents one operation after a random gap and waits for its accept edge.
  task automatic send_op(logic [1:0] op, logic [KEY_PORT_W-1:0] key, logic typed,
                         outcome_t want);
    int unsigned gap;
    outcome_t    predicted;
    gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy);
      repeat (gap) @(negedge clk_i);
    end
    start    <= 1'b1;
    opcode_i <= op;
    key_i    <= key;
    do @(posedge clk_i); while (busy);
    predicted = apply_set_op(op, key);
    pending_q.insert(pending_q.size(), typed ? want : predicted);
    ops_sent++;
  endtask

  // Writes the bucket count once the block has drained and gone idle.
  task automatic set_buckets(logic [BCOUNT_W-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0 || busy);
    @(negedge clk_i);
    bucket_count_we_i <= 1'b1;
    bucket_count_i    <= value;
    @(negedge clk_i);
    bucket_count_we_i <= 1'b0;
    cfg_buckets = value;
    settings_used++;
  endtask

  // Random operations; keys mostly collide so that hits and full buckets occur.
  task automatic run_random(int unsigned items, int unsigned add_pct);
    logic [KEY_PORT_W-1:0] pool [8];
    logic [1:0]            op;
    logic [KEY_PORT_W-1:0] key;
    int unsigned           roll;
    int unsigned           divisor;
    foreach (pool[j]) pool[j] = $urandom;
    divisor = (cfg_buckets == 0) ? 1 : ((cfg_buckets > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF
                                                                      : cfg_buckets);
    for (int unsigned i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) op = OP_ADD;
      else if (roll < add_pct + (100 - add_pct) / 2) op = OP_REMOVE;
      else if (roll < 95) op = OP_CONTAINS;
      else op = OP_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 45) key = $urandom_range(0, 511);
      else if (roll < 65) key = pool[$urandom_range(0, 7)];
      else if (roll < 80) key = pool[$urandom_range(0, 7)] + divisor * $urandom_range(1, 5);
      else if (roll < 95) key = $urandom;
      else key = ($urandom_range(0, 1) != 0) ? '1 : '0;
      send_op(op, key, 1'b0, '0);
    end
  endtask

  // Result checker: each beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      got.was_present = was_present_o;
      got.status      = status_e'(status_o);
      got.count       = element_count_o;
      got.empty       = is_empty_o;
      results_seen++;
      if (got.status == STS_FULL) full_rejects++;
      if (got.count > peak_count) peak_count = got.count;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        want = pending_q.pop_front();
        check_field("was_present", want.was_present, got.was_present);
        check_field("status", want.status, got.status);
        check_field("element_count", want.count, got.count);
        check_field("is_empty", want.empty, got.empty);
      end
    end
  end

  // Bucket counts for the random phases, extremes first; add weight per phase.
  logic [BCOUNT_W-1:0] phase_buckets [PHASES];
  int unsigned         phase_add_pct [PHASES];

  initial begin
    rst_ni            <= 1'b0;
    start             <= 1'b0;
    opcode_i          <= OP_ADD;
    key_i             <= '0;
    bucket_count_we_i <= 1'b0;
    bucket_count_i    <= '0;
    mismatches    = 0;
    ops_sent      = 0;
    results_seen  = 0;
    full_rejects  = 0;
    peak_count    = 0;
    settings_used = 0;
    idle_off      = 1'b0;
    shadow_count  = 0;
    cfg_buckets   = RESET_BUCKETS;
    foreach (shadow_used[s]) shadow_used[s] = 1'b0;
    foreach (shadow_key[s]) shadow_key[s] = '0;

    // Directed table, run under the reset bucket count of 100.
    // Keys 5, 105, 205, 305 and 405 all land in bucket 5.
    dir_rows = '{
      '{OP_CONTAINS, 32'd0,          1'b1, '{1'b0, STS_NOCHANGE, 10'd0, 1'b1}},
      '{OP_REMOVE,   32'd0,          1'b1, '{1'b0, STS_NOCHANGE, 10'd0, 1'b1}},
      '{OP_ADD,      32'd0,          1'b1, '{1'b0, STS_DONE,     10'd1, 1'b0}},
      '{OP_ADD,      32'd0,          1'b1, '{1'b1, STS_NOCHANGE, 10'd1, 1'b0}},
      '{OP_CONTAINS, 32'd0,          1'b1, '{1'b1, STS_DONE,     10'd1, 1'b0}},
      '{OP_UNUSED,   32'd0,          1'b1, '{1'b1, STS_DONE,     10'd1, 1'b0}},
      '{OP_ADD,      32'hFFFF_FFFF,  1'b1, '{1'b0, STS_DONE,     10'd2, 1'b0}},
      '{OP_CONTAINS, 32'hFFFF_FFFF,  1'b1, '{1'b1, STS_DONE,     10'd2, 1'b0}},
      '{OP_ADD,      32'd5,          1'b1, '{1'b0, STS_DONE,     10'd3, 1'b0}},
      '{OP_ADD,      32'd105,        1'b1, '{1'b0, STS_DONE,     10'd4, 1'b0}},
      '{OP_ADD,      32'd205,        1'b1, '{1'b0, STS_DONE,     10'd5, 1'b0}},
      '{OP_ADD,      32'd305,        1'b1, '{1'b0, STS_DONE,     10'd6, 1'b0}},
      '{OP_ADD,      32'd405,        1'b1, '{1'b0, STS_FULL,     10'd6, 1'b0}},
      '{OP_CONTAINS, 32'd405,        1'b1, '{1'b0, STS_NOCHANGE, 10'd6, 1'b0}},
      '{OP_REMOVE,   32'd205,        1'b1, '{1'b1, STS_DONE,     10'd5, 1'b0}},
      '{OP_ADD,      32'd405,        1'b0, '0},
      '{OP_UNUSED,   32'd999,        1'b1, '{1'b0, STS_NOCHANGE, 10'd6, 1'b0}},
      '{OP_REMOVE,   32'd0,          1'b1, '{1'b1, STS_DONE,     10'd5, 1'b0}},
      '{OP_ADD,      32'h8000_0000,  1'b0, '0},
      '{OP_ADD,      32'hAAAA_5555,  1'b0, '0},
      '{OP_ADD,      32'h5555_AAAA,  1'b0, '0},
      '{OP_REMOVE,   32'hFFFF_FFFF,  1'b0, '0},
      '{OP_CONTAINS, 32'd99,         1'b0, '0}
    };
    phase_buckets = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd2, 8'd100,
                      8'($urandom_range(1, 128)), 8'($urandom_range(0, 255)),
                      8'd128, 8'd7, 8'd64};
    phase_add_pct = '{45, 45, 45, 40, 45, 45, 45, 45, 85, 45, 50};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) send_op(dir_rows[r].op, dir_rows[r].key, dir_rows[r].typed,
                                  dir_rows[r].want);

    // Stored keys are kept across bucket-count changes on purpose.
    for (int p = 0; p < PHASES; p++) begin
      set_buckets(phase_buckets[p]);
      idle_off = ($urandom_range(0, 3) == 0);
      run_random(90, phase_add_pct[p]);
    end

    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) mismatches += pending_q.size();

    $display("Ran %0d operations under %0d bucket-count settings; %0d results checked.",
             ops_sent, settings_used + 1, results_seen);
    $display("Peak element count %0d, %0d adds rejected on a full bucket.",
             peak_count, full_rejects);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bhs_pkg.sv
rtl/core/bhs_ram.sv
rtl/core/bhs_ctrl.sv
rtl/core/bhs_dp.sv
rtl/core/bucketed_hash_set.sv
rtl/core/bhs_checker.sv
tb/sv/bucketed_hash_set_test.sv
